### src/sdl_pkg.sv
// ----------------------------------------------------------------------------
// sdl_pkg: sample descriptor lookup shared definitions
// Widths, table geometry, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package sdl_pkg;

    localparam int C_MAX_ENTRIES  = 256;
    localparam int C_FILTER_SLOTS = 4;

    localparam int C_ADDR_W  = (C_MAX_ENTRIES > 1) ? $clog2(C_MAX_ENTRIES) : 1;
    localparam int C_IDX_W   = 8;
    localparam int C_WORD_W  = 16;
    localparam int C_FILT_W  = 32;
    localparam int C_ENTRY_W = C_WORD_W + C_FILT_W;
    localparam int C_OFFS_W  = 25;
    localparam int C_FCNT_W  = 3;
    localparam int C_CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [C_CFG_IDX_W-1:0] C_REG_SAMPLE_COUNT = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_FILTER_COUNT = 2'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_BANK_TOTAL   = 2'd2;

    // input actions
    localparam logic C_ACT_WRITE = 1'b0;
    localparam logic C_ACT_QUERY = 1'b1;

    // bit 15 of an entry word marks a redirect
    localparam int C_REDIR_BIT = 15;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ENT  = 4'b0010,
        S_TGT  = 4'b0100,
        S_CHK  = 4'b1000
    } t_state;

endpackage

### src/sample_descriptor_lookup_core.sv
// ----------------------------------------------------------------------------
// sample_descriptor_lookup_core: sample descriptor lookup
// Stores sound-sample entries and answers descriptor queries by walking the
// entry table one read per cycle.
// ----------------------------------------------------------------------------
//
// Channel      Direction  Handshake                    Payload
// -----------  ---------  ---------------------------  ------------------------------
// item in      in         i_start, o_busy              action, index, entry word/filters
// result out   out        o_valid (one-cycle strobe)   found, start, length, filters
// config       in         i_cfg_valid, o_cfg_ready     i_cfg_index, i_cfg_data
//
// A write item leaves the sequencer idle; the next item may follow straight away.
// A query with an index at or above the sample count answers in the next cycle.
// Any other query reads its entry, then any redirect target, then scans the
// following entries for the end offset through the single read port of the
// entry table. Reset clears the sequencer, result strobe and config registers;
// the table holds whatever was written. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module sample_descriptor_lookup_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // item channel
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic                                 i_action,
    input  logic [sdl_pkg::C_IDX_W-1:0]          i_index,
    input  logic [sdl_pkg::C_WORD_W-1:0]         i_entry_word,
    input  logic [sdl_pkg::C_FILT_W-1:0]         i_entry_filters,
    // result channel
    output logic                                 o_valid,
    output logic                                 o_found,
    output logic signed [sdl_pkg::C_OFFS_W-1:0]  o_start_offset,
    output logic signed [sdl_pkg::C_OFFS_W-1:0]  o_sample_length,
    output logic [sdl_pkg::C_FCNT_W-1:0]         o_used_filters,
    output logic [sdl_pkg::C_FILT_W-1:0]         o_filter_bytes,
    // configuration channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sdl_pkg::C_CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sdl_pkg::C_WORD_W-1:0]         i_cfg_data
);

    // configuration registers
    logic [sdl_pkg::C_IDX_W-1:0]  r_sample_count;
    logic [sdl_pkg::C_FCNT_W-1:0] r_filter_count;
    logic [sdl_pkg::C_WORD_W-1:0] r_bank_total;

    // sequencer and working registers
    sdl_pkg::t_state r_state, n_state;
    logic [sdl_pkg::C_IDX_W-1:0]  r_at, n_at;        // entry that gave the start word
    logic [sdl_pkg::C_IDX_W:0]    r_next, n_next;    // entry under scan
    logic [sdl_pkg::C_WORD_W-1:0] r_start_w, n_start_w;
    logic                         r_rd_oob;

    // result registers
    logic                                 r_valid, n_valid;
    logic                                 r_found, n_found;
    logic signed [sdl_pkg::C_OFFS_W-1:0]  r_start_off, n_start_off;
    logic signed [sdl_pkg::C_OFFS_W-1:0]  r_len, n_len;
    logic [sdl_pkg::C_FCNT_W-1:0]         r_used, n_used;
    logic [sdl_pkg::C_FILT_W-1:0]         r_filt, n_filt;

    // table access
    logic                            wr_en;
    logic [sdl_pkg::C_IDX_W-1:0]     rd_idx;
    logic [sdl_pkg::C_ENTRY_W-1:0]   ram_rd_data;
    logic [sdl_pkg::C_ENTRY_W-1:0]   ent;
    logic [sdl_pkg::C_WORD_W-1:0]    ent_word;
    logic [sdl_pkg::C_FILT_W-1:0]    ent_filt;

    // shared scan step
    logic [sdl_pkg::C_IDX_W:0]       inc_base;
    logic [sdl_pkg::C_IDX_W:0]       inc;
    logic                            inc_past_end;
    logic                            launch;
    logic                            fin;
    logic [sdl_pkg::C_WORD_W-1:0]    fin_end_w;
    logic [sdl_pkg::C_WORD_W-1:0]    cur_start_w;
    logic [sdl_pkg::C_OFFS_W-1:0]    start25;
    logic [sdl_pkg::C_OFFS_W-1:0]    end25;
    logic [sdl_pkg::C_FCNT_W-1:0]    used_cap;
    logic [sdl_pkg::C_FILT_W-1:0]    filt_masked;

    sdl_ram #(
        .P_WIDTH (sdl_pkg::C_ENTRY_W),
        .P_DEPTH (sdl_pkg::C_MAX_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_index[sdl_pkg::C_ADDR_W-1:0]),
        .i_wr_data ({i_entry_filters, i_entry_word}),
        .i_rd_addr (rd_idx[sdl_pkg::C_ADDR_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // Reads beyond the table give an all-zero entry.
    assign ent      = r_rd_oob ? '0 : ram_rd_data;
    assign ent_word = ent[sdl_pkg::C_WORD_W-1:0];
    assign ent_filt = ent[sdl_pkg::C_ENTRY_W-1:sdl_pkg::C_WORD_W];

    // Cap the filter count at the number of slots.
    assign used_cap = (r_filter_count > sdl_pkg::C_FCNT_W'(sdl_pkg::C_FILTER_SLOTS))
                    ? sdl_pkg::C_FCNT_W'(sdl_pkg::C_FILTER_SLOTS) : r_filter_count;

    // Keep the bytes of the used slots, fill the rest with 0xff.
    always_comb begin
        filt_masked = '1;
        for (int s = 0; s < sdl_pkg::C_FILTER_SLOTS; s++) begin
            if (sdl_pkg::C_FCNT_W'(s) < used_cap) begin
                filt_masked[8*s +: 8] = ent_filt[8*s +: 8];
            end
        end
    end

    // One incrementer and one compare serve every scan step.
    assign inc_base     = (r_state == sdl_pkg::S_CHK) ? r_next : {1'b0, r_at};
    assign inc          = inc_base + 1'b1;
    assign inc_past_end = inc >= {1'b0, r_sample_count};

    assign cur_start_w = (r_state == sdl_pkg::S_CHK) ? r_start_w : ent_word;
    assign start25     = {1'b0, cur_start_w, 8'h00};
    assign end25       = {1'b0, fin_end_w, 8'h00};

    always_comb begin
        n_state     = r_state;
        n_at        = r_at;
        n_next      = r_next;
        n_start_w   = r_start_w;
        n_valid     = 1'b0;
        n_found     = r_found;
        n_start_off = r_start_off;
        n_len       = r_len;
        n_used      = r_used;
        n_filt      = r_filt;
        wr_en       = 1'b0;
        rd_idx      = inc[sdl_pkg::C_IDX_W-1:0];
        launch      = 1'b0;
        fin         = 1'b0;
        fin_end_w   = r_bank_total;

        unique case (r_state)
            sdl_pkg::S_IDLE: begin
                rd_idx = i_index;
                n_at   = i_index;
                if (i_start) begin
                    if (i_action == sdl_pkg::C_ACT_WRITE) begin
                        // drop writes beyond the table
                        wr_en = {1'b0, i_index} < (sdl_pkg::C_IDX_W + 1)'(sdl_pkg::C_MAX_ENTRIES);
                    end else if (i_index >= r_sample_count) begin
                        // empty descriptor
                        n_valid     = 1'b1;
                        n_found     = 1'b0;
                        n_start_off = '1;
                        n_len       = '0;
                        n_used      = '0;
                        n_filt      = '1;
                    end else begin
                        n_state = sdl_pkg::S_ENT;
                    end
                end
            end
            sdl_pkg::S_ENT: begin
                n_filt = filt_masked;
                n_used = used_cap;
                if (ent_word[sdl_pkg::C_REDIR_BIT]) begin
                    // follow the redirect one level
                    n_at    = ent_word[sdl_pkg::C_IDX_W-1:0];
                    rd_idx  = ent_word[sdl_pkg::C_IDX_W-1:0];
                    n_state = sdl_pkg::S_TGT;
                end else begin
                    n_start_w = ent_word;
                    launch    = 1'b1;
                end
            end
            sdl_pkg::S_TGT: begin
                // target word taken whole, redirect bit included
                n_start_w = ent_word;
                launch    = 1'b1;
            end
            sdl_pkg::S_CHK: begin
                if (ent_word[sdl_pkg::C_REDIR_BIT]) begin
                    launch = 1'b1;
                end else begin
                    fin       = 1'b1;
                    fin_end_w = ent_word;
                end
            end
            default: begin
                n_state = sdl_pkg::S_IDLE;
            end
        endcase

        // Advance the scan, or stop at the end of the bank.
        if (launch) begin
            if (inc_past_end) begin
                fin = 1'b1;
            end else begin
                n_next  = inc;
                n_state = sdl_pkg::S_CHK;
            end
        end

        if (fin) begin
            n_valid     = 1'b1;
            n_found     = 1'b1;
            n_start_off = start25;
            n_len       = end25 - start25;
            n_state     = sdl_pkg::S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= sdl_pkg::S_IDLE;
            r_valid        <= 1'b0;
            r_sample_count <= '0;
            r_filter_count <= '0;
            r_bank_total   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    sdl_pkg::C_REG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[sdl_pkg::C_IDX_W-1:0];
                    sdl_pkg::C_REG_FILTER_COUNT: r_filter_count <= i_cfg_data[sdl_pkg::C_FCNT_W-1:0];
                    sdl_pkg::C_REG_BANK_TOTAL:   r_bank_total   <= i_cfg_data;
                    default: begin
                        // hold: no register at this index
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_at        <= n_at;
        r_next      <= n_next;
        r_start_w   <= n_start_w;
        r_found     <= n_found;
        r_start_off <= n_start_off;
        r_len       <= n_len;
        r_used      <= n_used;
        r_filt      <= n_filt;
        r_rd_oob    <= {1'b0, rd_idx} >= (sdl_pkg::C_IDX_W + 1)'(sdl_pkg::C_MAX_ENTRIES);
    end

    assign o_busy          = (r_state != sdl_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_valid;
    assign o_found         = r_found;
    assign o_start_offset  = r_start_off;
    assign o_sample_length = r_len;
    assign o_used_filters  = r_used;
    assign o_filter_bytes  = r_filt;

endmodule

### src/sdl_ram.sv
// ----------------------------------------------------------------------------
// sdl_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sdl_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [P_WIDTH-1:0]                          i_wr_data,
    input  logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_rd_addr,
    output logic [P_WIDTH-1:0]                          o_rd_data
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/sdl_checker.sv
// ----------------------------------------------------------------------------
// sdl_checker: port-level checks for the sample descriptor lookup
// Watches the top-level ports and flags sequencing and result slips.
// ----------------------------------------------------------------------------
module sdl_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_start,
    input logic                                 o_busy,
    input logic                                 i_action,
    input logic                                 o_valid,
    input logic                                 o_found,
    input logic signed [sdl_pkg::C_OFFS_W-1:0]  o_start_offset,
    input logic signed [sdl_pkg::C_OFFS_W-1:0]  o_sample_length,
    input logic [sdl_pkg::C_FCNT_W-1:0]         o_used_filters,
    input logic [sdl_pkg::C_FILT_W-1:0]         o_filter_bytes
);

    // a result transfer ends the job
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobe while busy");

    // an empty descriptor carries the fixed fill values
    a_empty_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_start_offset == -1 && o_sample_length == 0 &&
                                   o_used_filters == 0 && o_filter_bytes == '1))
        else $error("malformed empty descriptor");

    // a write causes no result and no busy cycle
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_action == sdl_pkg::C_ACT_WRITE) |=> (!o_busy && !o_valid))
        else $error("write item produced activity");

    // a query either answers next cycle or starts work
    a_query_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_action == sdl_pkg::C_ACT_QUERY) |=> (o_busy || o_valid))
        else $error("query item dropped");

    // filter count never exceeds the slot count
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_used_filters <= sdl_pkg::C_FCNT_W'(sdl_pkg::C_FILTER_SLOTS))
        else $error("used filter count above slot count");

endmodule

bind sample_descriptor_lookup_core sdl_checker u_sdl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .i_action        (i_action),
    .o_valid         (o_valid),
    .o_found         (o_found),
    .o_start_offset  (o_start_offset),
    .o_sample_length (o_sample_length),
    .o_used_filters  (o_used_filters),
    .o_filter_bytes  (o_filter_bytes)
);

### tb/tb_sample_descriptor_lookup_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sample_descriptor_lookup_core: self-checking bench for the lookup core
// Loads entry tables, drives write and query commands with random gaps, and
// compares every descriptor strobe against a cycle-free predictor of the
// table walk. Registers are reprogrammed between phases while the core idles.
// ----------------------------------------------------------------------------
module tb_sample_descriptor_lookup_core;

    import sdl_pkg::*;

    // register index with no register behind it; a write there must be harmless
    localparam logic [C_CFG_IDX_W-1:0] C_REG_UNUSED = 2'd3;

    localparam int C_TIMEOUT_NS    = 4_000_000;
    localparam int C_DRAIN_LIMIT   = 2000;
    localparam int C_SETTLE_CYCLES = 8;

    typedef struct {
        logic                action;
        logic [C_IDX_W-1:0]  index;
        logic [C_WORD_W-1:0] word;
        logic [C_FILT_W-1:0] filters;
    } t_sample_cmd;

    typedef struct {
        logic                       found;
        logic signed [C_OFFS_W-1:0] start_offset;
        logic signed [C_OFFS_W-1:0] sample_length;
        logic [C_FCNT_W-1:0]        used_filters;
        logic [C_FILT_W-1:0]        filter_bytes;
    } t_descriptor;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_start;
    logic                       o_busy;
    logic                       i_action;
    logic [C_IDX_W-1:0]         i_index;
    logic [C_WORD_W-1:0]        i_entry_word;
    logic [C_FILT_W-1:0]        i_entry_filters;
    logic                       o_valid;
    logic                       o_found;
    logic signed [C_OFFS_W-1:0] o_start_offset;
    logic signed [C_OFFS_W-1:0] o_sample_length;
    logic [C_FCNT_W-1:0]        o_used_filters;
    logic [C_FILT_W-1:0]        o_filter_bytes;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [C_CFG_IDX_W-1:0]     i_cfg_index;
    logic [C_WORD_W-1:0]        i_cfg_data;

    sample_descriptor_lookup_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_action        (i_action),
        .i_index         (i_index),
        .i_entry_word    (i_entry_word),
        .i_entry_filters (i_entry_filters),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_start_offset  (o_start_offset),
        .o_sample_length (o_sample_length),
        .o_used_filters  (o_used_filters),
        .o_filter_bytes  (o_filter_bytes),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // commands waiting for the driver, and descriptors still owed by the core
    t_sample_cmd sample_cmds[$];
    t_descriptor expected_descriptors[$];

    // predictor copy of the table and registers, advanced at each transfer
    logic [C_WORD_W-1:0] tbl_word [C_MAX_ENTRIES];
    logic [C_FILT_W-1:0] tbl_filt [C_MAX_ENTRIES];
    logic [C_IDX_W-1:0]  cfg_samples;
    logic [C_FCNT_W-1:0] cfg_filters;
    logic [C_WORD_W-1:0] cfg_total;

    // generator view: which entries will have been written by the time a
    // queued query reaches the core, so that no query walks unwritten entries
    bit                  gen_written [C_MAX_ENTRIES];
    logic [C_IDX_W-1:0]  written_idx[$];
    logic [C_IDX_W-1:0]  gen_samples;

    int          mismatches = 0;
    int          gap_pct    = 12;
    bit          cmd_taken  = 1'b0;
    t_sample_cmd drive_cmd;
    t_descriptor want;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(C_TIMEOUT_NS);
        $display("tb_sample_descriptor_lookup_core NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Predictor: the descriptor the core owes for a query of sample idx
    // ------------------------------------------------------------------------
    function automatic t_descriptor lookup_descriptor(input logic [C_IDX_W-1:0] idx);
        t_descriptor         d;
        int unsigned         used;
        int unsigned         at;
        int unsigned         nxt;
        int                  s;
        logic [C_WORD_W-1:0] word;
        logic [C_WORD_W-1:0] nw;
        logic [C_OFFS_W-1:0] start_off;
        logic [C_OFFS_W-1:0] end_off;
        bit                  done;

        // empty descriptor for a miss
        d.found         = 1'b0;
        d.start_offset  = '1;
        d.sample_length = '0;
        d.used_filters  = '0;
        d.filter_bytes  = '1;
        if (idx >= cfg_samples)
            return d;

        // cap the filter count at the number of slots; unused slots stay 0xff
        used = (cfg_filters > C_FILTER_SLOTS) ? C_FILTER_SLOTS : cfg_filters;
        for (s = 0; s < C_FILTER_SLOTS; s++) begin
            if (s < used)
                d.filter_bytes[8*s +: 8] = tbl_filt[idx][8*s +: 8];
        end

        // follow one redirect only; a chained target keeps its bit 15
        at   = idx;
        word = tbl_word[idx];
        if (word[C_REDIR_BIT]) begin
            at   = word[7:0];
            word = tbl_word[at];
        end
        start_off = {1'b0, word, 8'h00};

        // scan past redirects to the next real start, else the bank end
        end_off = {1'b0, cfg_total, 8'h00};
        nxt     = at + 1;
        done    = 1'b0;
        while (!done && nxt < cfg_samples) begin
            nw = tbl_word[nxt];
            if (nw[C_REDIR_BIT]) begin
                nxt++;
            end else begin
                end_off = {1'b0, nw, 8'h00};
                done    = 1'b1;
            end
        end

        d.found         = 1'b1;
        d.start_offset  = start_off;
        d.sample_length = end_off - start_off;
        d.used_filters  = used[C_FCNT_W-1:0];
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // Command driver: present a new command once the previous one has
    // transferred, or idle at random; payload is junk while idle
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || cmd_taken) begin
            if (sample_cmds.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
                drive_cmd        = sample_cmds.pop_front();
                i_start         <= 1'b1;
                i_action        <= drive_cmd.action;
                i_index         <= drive_cmd.index;
                i_entry_word    <= drive_cmd.word;
                i_entry_filters <= drive_cmd.filters;
            end else begin
                i_start         <= 1'b0;
                i_action        <= 1'($urandom);
                i_index         <= 8'($urandom);
                i_entry_word    <= 16'($urandom);
                i_entry_filters <= $urandom;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check strobed descriptors, track register writes, and predict
    // for each command transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cmd_taken <= i_rst_n && i_start && !o_busy;
        if (!i_rst_n) begin
            cfg_samples = '0;
            cfg_filters = '0;
            cfg_total   = '0;
        end else begin
            // check first: a strobe at this edge cannot belong to a command
            // transferred at this same edge
            if (o_valid) begin
                if (expected_descriptors.size() == 0) begin
                    report_mismatch("descriptor strobe with no query outstanding");
                end else begin
                    want = expected_descriptors.pop_front();
                    if (o_found !== want.found)
                        report_mismatch($sformatf("found got %0b want %0b",
                                                  o_found, want.found));
                    if (o_start_offset !== want.start_offset)
                        report_mismatch($sformatf("start_offset got %0d want %0d",
                                                  o_start_offset, want.start_offset));
                    if (o_sample_length !== want.sample_length)
                        report_mismatch($sformatf("sample_length got %0d want %0d",
                                                  o_sample_length, want.sample_length));
                    if (o_used_filters !== want.used_filters)
                        report_mismatch($sformatf("used_filters got %0d want %0d",
                                                  o_used_filters, want.used_filters));
                    if (o_filter_bytes !== want.filter_bytes)
                        report_mismatch($sformatf("filter_bytes got %08h want %08h",
                                                  o_filter_bytes, want.filter_bytes));
                end
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    C_REG_SAMPLE_COUNT: cfg_samples = i_cfg_data[C_IDX_W-1:0];
                    C_REG_FILTER_COUNT: cfg_filters = i_cfg_data[C_FCNT_W-1:0];
                    C_REG_BANK_TOTAL:   cfg_total   = i_cfg_data;
                    default: ;  // no register here: drop the write
                endcase
            end

            if (i_start && !o_busy) begin
                if (i_action == C_ACT_WRITE) begin
                    tbl_word[i_index] = i_entry_word;
                    tbl_filt[i_index] = i_entry_filters;
                end else begin
                    expected_descriptors.push_back(lookup_descriptor(i_index));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_entry(input logic [C_IDX_W-1:0] idx,
                               input logic [C_WORD_W-1:0] word,
                               input logic [C_FILT_W-1:0] filters);
        t_sample_cmd c;
        if (!gen_written[idx]) begin
            gen_written[idx] = 1'b1;
            written_idx.push_back(idx);
        end
        c.action  = C_ACT_WRITE;
        c.index   = idx;
        c.word    = word;
        c.filters = filters;
        sample_cmds.push_back(c);
    endtask

    // random entry; a redirect only ever points at a written entry or itself
    task automatic queue_random_entry(input logic [C_IDX_W-1:0] idx, input int redir_pct);
        int                  k;
        logic [C_IDX_W-1:0]  tgt;
        logic [C_WORD_W-1:0] word;
        if ($urandom_range(0, 99) < redir_pct) begin
            k    = $urandom_range(0, written_idx.size());
            tgt  = (k == written_idx.size()) ? idx : written_idx[k];
            word = {1'b1, 7'($urandom), tgt};
        end else begin
            word = {1'b0, 15'($urandom)};
        end
        queue_entry(idx, word, $urandom);
    endtask

    task automatic queue_query(input logic [C_IDX_W-1:0] idx);
        t_sample_cmd c;
        c.action  = C_ACT_QUERY;
        c.index   = idx;
        c.word    = 16'($urandom);
        c.filters = $urandom;
        sample_cmds.push_back(c);
    endtask

    // hold until every queued command has transferred and every descriptor
    // has arrived or the drain limit is hit, then let a trailing write settle
    task automatic drain_results();
        int n;
        while (sample_cmds.size() > 0 || i_start)
            @(posedge i_clk);
        n = 0;
        while (expected_descriptors.size() > 0 && n < C_DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (C_SETTLE_CYCLES) @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx,
                             input logic [C_WORD_W-1:0] data);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct)
            @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 16'($urandom);
    endtask

    // reprogram while idle, then fill any unwritten entry below the new
    // sample count so every later query walks written entries only
    task automatic configure(input logic [C_IDX_W-1:0] samples,
                             input logic [C_FCNT_W-1:0] filters,
                             input logic [C_WORD_W-1:0] total,
                             input int redir_pct);
        int i;
        drain_results();
        // upper data bits are junk: the core keeps only the register width
        write_reg(C_REG_SAMPLE_COUNT, {8'($urandom), samples});
        write_reg(C_REG_FILTER_COUNT, {13'($urandom), filters});
        write_reg(C_REG_BANK_TOTAL, total);
        write_reg(C_REG_UNUSED, 16'($urandom));
        gen_samples = samples;
        for (i = 0; i < samples; i++) begin
            if (!gen_written[i])
                queue_random_entry(8'(i), redir_pct);
        end
    endtask

    // mostly well-formed queries inside the bank, some anywhere, some writes
    task automatic run_phase(input logic [C_IDX_W-1:0] samples,
                             input logic [C_FCNT_W-1:0] filters,
                             input logic [C_WORD_W-1:0] total,
                             input int n_cmds,
                             input int redir_pct);
        int roll;
        configure(samples, filters, total, redir_pct);
        repeat (n_cmds) begin
            roll = $urandom_range(0, 99);
            if (roll < 55 && gen_samples > 0)
                queue_query(8'($urandom_range(0, gen_samples - 1)));
            else if (roll < 70)
                queue_query(8'($urandom_range(0, 255)));
            else
                queue_random_entry(8'($urandom_range(0, 255)), redir_pct);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_action        = C_ACT_WRITE;
        i_index         = '0;
        i_entry_word    = '0;
        i_entry_filters = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = C_REG_SAMPLE_COUNT;
        i_cfg_data      = '0;
        gen_samples     = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // out of reset the sample count is zero: every query misses
        queue_query(8'd0);

        // hand-built bank: extremes, a redirect past the sample count, a
        // chained redirect, a self redirect, and a run of redirects to skip
        queue_entry(8'd200, 16'h1234, 32'h89ab_cdef);
        queue_entry(8'd0,   16'h0000, 32'h0000_0000);
        queue_entry(8'd1,   16'h7fff, 32'hffff_ffff);
        queue_entry(8'd2,   16'hffc8, 32'h1122_3344);  // redirect to 200
        queue_entry(8'd3,   16'h8002, 32'h5566_7788);  // redirect to a redirect
        queue_entry(8'd4,   16'h8000, 32'ha5a5_5a5a);  // redirect to 0
        queue_entry(8'd5,   16'h4000, 32'h0f0f_0f0f);
        queue_entry(8'd6,   16'h8006, 32'hf0f0_f0f0);  // redirect to itself
        queue_entry(8'd7,   16'h0001, 32'h7654_3210);
        queue_entry(8'd255, 16'h5555, 32'haaaa_5555);
        queue_query(8'd5);

        configure(8'd8, 3'd4, 16'hffff, 30);
        for (int q = 0; q <= 8; q++)
            queue_query(8'(q));
        queue_query(8'd255);

        // random phases across register settings, extremes included
        run_phase(8'd16,  3'd5, 16'($urandom), 60, 30);
        run_phase(8'd1,   3'd0, 16'h0000,      30, 30);
        gap_pct = 0;    // stretch with the command side never idling
        run_phase(8'd40,  3'd6, 16'($urandom), 80, 40);
        gap_pct = 12;
        run_phase(8'd0,   3'd1, 16'hffff,      20, 30);
        run_phase(8'd100, 3'd7, 16'($urandom), 70, 50);
        // full bank, redirect-heavy so that some scans run long
        run_phase(8'd255, 3'd3, 16'hffff,      60, 85);

        drain_results();
        if (expected_descriptors.size() != 0)
            report_mismatch($sformatf("%0d descriptors never arrived",
                                      expected_descriptors.size()));
        repeat (C_SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_sample_descriptor_lookup_core OK");
        end else begin
            $display("tb_sample_descriptor_lookup_core NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
src/sdl_pkg.sv
src/sdl_ram.sv
src/sample_descriptor_lookup_core.sv
src/sdl_checker.sv
tb/tb_sample_descriptor_lookup_core.sv
